// ===== design/bvm_pkg.sv =====
// Package: constants, opcodes and status codes of the byte VM execute unit.
`default_nettype none
package bvm_pkg;
   localparam int RegCount = 16;
   localparam int LocalDepth = 256;
   localparam int GlobalDepth = 256;
   localparam int RegAw = $clog2(RegCount);
   localparam int LocalAw = $clog2(LocalDepth);
   localparam int GlobalAw = $clog2(GlobalDepth);

   typedef enum logic [1:0] {
      MODE_EXEC = 2'd0, MODE_LDG = 2'd1, MODE_LDL = 2'd2, MODE_PC = 2'd3
   } mode_type;

   localparam logic [7:0] OP_LLOAD = 8'h01, OP_LLOADI = 8'h02, OP_GLOAD = 8'h03,
      OP_GLOADI = 8'h04, OP_LSTORE = 8'h05, OP_LSTOREI = 8'h06, OP_GSTORE = 8'h07,
      OP_GSTOREI = 8'h08, OP_SET = 8'h09, OP_ADD = 8'h0a, OP_SUB = 8'h0b,
      OP_MUL = 8'h0c, OP_DIV = 8'h0d, OP_MOD = 8'h0e, OP_BRGZ = 8'h0f,
      OP_BRGEZ = 8'h10, OP_BRLZ = 8'h11, OP_BRLEZ = 8'h12, OP_BREZ = 8'h13,
      OP_BRA = 8'h14, OP_DOWN = 8'h15, OP_UP = 8'h16, OP_YIELD = 8'h17,
      OP_SLEEP = 8'h18, OP_PRINT = 8'h19, OP_EXIT = 8'h1a;

   localparam logic [3:0] ST_OK = 4'd0, ST_YIELD = 4'd1, ST_BLOCKED = 4'd2,
      ST_WAKE = 4'd3, ST_SLEEP = 4'd4, ST_STOPPED = 4'd5, ST_PRINT = 4'd6,
      ST_BADOP = 4'd7, ST_DIVZERO = 4'd8;
endpackage
`default_nettype wire

// ===== design/bvm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bvm_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/bvm_divider.sv =====
// Iterative 8-bit signed divider, one quotient bit per cycle.
`default_nettype none
module bvm_divider import bvm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic signed [7:0] dividend,
   input  wire logic signed [7:0] divisor,
   output logic                   done,
   output logic        [7:0]      quotient,
   output logic        [7:0]      remainder
);
   logic [7:0] num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [8:0] rem_ff, rem_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic       fin_ff;
   logic [8:0] trial;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      trial = {rem_ff[7:0], num_ff[7]} - {1'b0, den_ff};
      if (start) begin
         num_in = dividend[7] ? 8'(-dividend) : dividend;
         den_in = divisor[7] ? 8'(-divisor) : divisor;
         qneg_in = dividend[7] ^ divisor[7];
         rneg_in = dividend[7];
         rem_in = '0;
         quo_in = '0;
         cnt_in = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[6:0], 1'b0};
         if (!trial[8]) begin
            rem_in = trial;
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = {rem_ff[7:0], num_ff[7]};
            quo_in = {quo_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= busy_ff && (cnt_ff == 4'd1);
      end
   end

   assign done = fin_ff;
   assign quotient = qneg_ff ? 8'(-quo_ff) : quo_ff;
   assign remainder = rneg_ff ? 8'(-rem_ff[7:0]) : rem_ff[7:0];
endmodule
`default_nettype wire

// ===== design/byte_vm_instruction_execute_top.sv =====
// Top level of the byte VM execute unit.
// One request at a time: a request is registered on acceptance, with the local or
// global memory read through its registered read port, and is completed in the
// next cycle (S_EXEC, which reads the register file and pc), so most requests go
// from S_IDLE through S_EXEC to S_RESP; DIV and MOD with a nonzero divisor wait
// in S_DIV for the bit-serial divider. Loads of memory bytes and the set-pc mode
// also go from S_EXEC straight to S_RESP. The response sits in an output
// register; the next request is taken in the cycle after it is handed off.
`default_nettype none
module byte_vm_instruction_execute_top import bvm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_opcode,
   input  wire logic [3:0]  req_reg_index,
   input  wire logic [7:0]  req_operand,
   input  wire logic [7:0]  req_load_address,
   input  wire logic [7:0]  req_load_data,
   input  wire logic [15:0] req_start_pc,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [15:0]      rsp_next_pc,
   output logic signed [8:0] rsp_event_value,
   output logic signed [7:0] rsp_written_value
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_DIV = 4'b0100, S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] regs_ff [RegCount];
   logic [15:0] pc_ff, pc_in;
   logic [1:0] mode_ff;
   logic [7:0] opc_ff, op_ff, ldata_ff;
   logic [3:0] ri_ff;
   logic [7:0] addr_ff;
   logic [3:0] status_ff, status_in;
   logic [15:0] npc_ff;
   logic [8:0] event_ff, event_in;
   logic [7:0] wr_ff, wr_in;

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // memory address for the request
   logic idx_op;
   logic [7:0] eaddr;
   always_comb begin
      idx_op = (req_opcode == OP_LLOADI) || (req_opcode == OP_GLOADI)
         || (req_opcode == OP_LSTOREI) || (req_opcode == OP_GSTOREI);
      eaddr = idx_op ? 8'(req_operand + regs_ff[0]) : req_operand;
   end

   logic [7:0] a_val, b_val;
   assign a_val = regs_ff[ri_ff];
   assign b_val = regs_ff[op_ff[3:0]];

   logic [7:0] lrd, grd;
   logic lwe, gwe;
   logic [7:0] mem_wdata;
   logic [LocalAw-1:0] lwa, lra;
   logic [GlobalAw-1:0] gwa, gra;
   assign lra = LocalAw'(eaddr);
   assign gra = GlobalAw'(eaddr);

   bvm_ram #(.Width(8), .Depth(LocalDepth)) u_local (
      .clock, .wr_en(lwe), .wr_addr(lwa), .wr_data(mem_wdata),
      .rd_addr(lra), .rd_data(lrd));
   bvm_ram #(.Width(8), .Depth(GlobalDepth)) u_global (
      .clock, .wr_en(gwe), .wr_addr(gwa), .wr_data(mem_wdata),
      .rd_addr(gra), .rd_data(grd));

   logic dstart;
   logic [7:0] dq, dr;
   logic ddone;
   bvm_divider u_div (
      .clock, .reset, .start(dstart), .dividend(a_val), .divisor(b_val),
      .done(ddone), .quotient(dq), .remainder(dr));

   logic reg_we;
   logic [7:0] reg_wd;
   logic [15:0] seq_pc, br_pc;
   logic [15:0] mul_full;
   logic cond;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      status_in = ST_OK;
      event_in = '0;
      wr_in = '0;
      lwe = 1'b0;
      gwe = 1'b0;
      lwa = LocalAw'(addr_ff);
      gwa = GlobalAw'(addr_ff);
      mem_wdata = a_val;
      reg_we = 1'b0;
      reg_wd = '0;
      dstart = 1'b0;
      seq_pc = pc_ff + 16'd3;
      br_pc = pc_ff + 16'({{8{op_ff[7]}}, op_ff} * 16'sd3);
      mul_full = 16'($signed(a_val) * $signed(b_val));
      cond = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            unique case (mode_ff)
               MODE_LDG: begin
                  gwe = 1'b1;
                  gwa = GlobalAw'(addr_ff);
                  mem_wdata = ldata_ff;
                  wr_in = ldata_ff;
               end
               MODE_LDL: begin
                  lwe = 1'b1;
                  lwa = LocalAw'(addr_ff);
                  mem_wdata = ldata_ff;
                  wr_in = ldata_ff;
               end
               MODE_PC: begin
               end
               default: begin
                  pc_in = seq_pc;
                  unique case (opc_ff) inside
                     OP_LLOAD, OP_LLOADI: begin
                        wr_in = lrd; reg_we = 1'b1; reg_wd = lrd;
                     end
                     OP_GLOAD, OP_GLOADI: begin
                        wr_in = grd; reg_we = 1'b1; reg_wd = grd;
                     end
                     OP_LSTORE, OP_LSTOREI: begin
                        wr_in = a_val; lwe = 1'b1;
                     end
                     OP_GSTORE, OP_GSTOREI: begin
                        wr_in = a_val; gwe = 1'b1;
                     end
                     OP_SET: begin
                        wr_in = op_ff; reg_we = 1'b1; reg_wd = op_ff;
                     end
                     OP_ADD: begin
                        wr_in = a_val + b_val; reg_we = 1'b1; reg_wd = wr_in;
                     end
                     OP_SUB: begin
                        wr_in = a_val - b_val; reg_we = 1'b1; reg_wd = wr_in;
                     end
                     OP_MUL: begin
                        wr_in = mul_full[7:0]; reg_we = 1'b1; reg_wd = wr_in;
                     end
                     OP_DIV, OP_MOD: begin
                        if (b_val == 8'd0) begin
                           status_in = ST_DIVZERO;
                           pc_in = pc_ff;
                        end else begin
                           pc_in = pc_ff;
                           dstart = 1'b1;
                           state_in = S_DIV;
                        end
                     end
                     OP_BRGZ, OP_BRGEZ, OP_BRLZ, OP_BRLEZ, OP_BREZ, OP_BRA: begin
                        case (opc_ff)
                           OP_BRGZ:  cond = !a_val[7] && (a_val != 8'd0);
                           OP_BRGEZ: cond = !a_val[7];
                           OP_BRLZ:  cond = a_val[7];
                           OP_BRLEZ: cond = a_val[7] || (a_val == 8'd0);
                           OP_BREZ:  cond = (a_val == 8'd0);
                           default:  cond = 1'b1;
                        endcase
                        if (cond) begin
                           pc_in = br_pc;
                        end
                     end
                     OP_DOWN, OP_UP: begin
                        wr_in = (opc_ff == OP_DOWN) ? grd - 8'd1 : grd + 8'd1;
                        mem_wdata = wr_in;
                        gwe = 1'b1;
                        event_in = {1'b0, op_ff};
                        if (opc_ff == OP_DOWN) begin
                           status_in = wr_in[7] ? ST_BLOCKED : ST_OK;
                        end else begin
                           status_in = (wr_in[7] || wr_in == 8'd0) ? ST_WAKE : ST_OK;
                        end
                     end
                     OP_YIELD: status_in = ST_YIELD;
                     OP_SLEEP: begin
                        status_in = ST_SLEEP;
                        event_in = {a_val[7], a_val};
                     end
                     OP_PRINT: begin
                        status_in = ST_PRINT;
                        event_in = {1'b0, op_ff};
                     end
                     OP_EXIT: begin
                        status_in = ST_STOPPED;
                        pc_in = pc_ff;
                     end
                     default: begin
                        status_in = ST_BADOP;
                        pc_in = pc_ff;
                     end
                  endcase
               end
            endcase
         end
         S_DIV: begin
            if (ddone) begin
               wr_in = (opc_ff == OP_DIV) ? dq : dr;
               reg_we = 1'b1;
               reg_wd = wr_in;
               pc_in = seq_pc;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic upd;
   assign upd = (state_ff == S_EXEC) || ((state_ff == S_DIV) && ddone);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         for (int i = 0; i < RegCount; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (upd) begin
            pc_ff <= (mode_ff == MODE_PC) ? npc_ff : pc_in;
         end
         if (reg_we) begin
            regs_ff[ri_ff] <= reg_wd;
         end
      end
      if (accept) begin
         mode_ff <= req_mode;
         opc_ff <= req_opcode;
         ri_ff <= req_reg_index;
         op_ff <= req_operand;
         ldata_ff <= req_load_data;
         addr_ff <= (req_mode == MODE_EXEC) ? eaddr : req_load_address;
         npc_ff <= req_start_pc;
      end
      if (upd) begin
         status_ff <= status_in;
         event_ff <= event_in;
         wr_ff <= wr_in;
         if (mode_ff != MODE_PC) begin
            npc_ff <= pc_in;
         end
      end
   end

   assign rsp_status = status_ff;
   assign rsp_next_pc = npc_ff;
   assign rsp_event_value = event_ff;
   assign rsp_written_value = wr_ff;

   property p_stall_busy;
      @(posedge clock) disable iff (reset) rsp_valid |-> req_stall;
   endproperty
   a_stall_busy: assert property (p_stall_busy) else $error("accept while busy");

   property p_exec_once;
      @(posedge clock) disable iff (reset) (state_ff == S_EXEC) |=> (state_ff != S_EXEC);
   endproperty
   a_exec_once: assert property (p_exec_once) else $error("exec repeated");

   property p_no_reg_write_idle;
      @(posedge clock) disable iff (reset) (state_ff == S_IDLE) |-> !reg_we && !lwe && !gwe;
   endproperty
   a_no_write_idle: assert property (p_no_reg_write_idle) else $error("write while idle");
endmodule
`default_nettype wire
